>>> rtl/core/hdec_pkg.sv
// Shared types, constants and the CRC-8 step function of the frame decoder.
package hdec_pkg;

   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 16;
   localparam int TEMP_CENTI_W  = 15;
   localparam int HUMID_CENTI_W = 14;
   localparam int PROD_W        = 31;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [13:0] HUMID_SCALE = 14'd10000;
   localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

   typedef struct packed {
      logic              status;
      logic [WORD_W-1:0] raw_temperature;
      logic [WORD_W-1:0] raw_humidity;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } queue_port_type;

   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/hdec_if.sv
// Valid/ready channel interfaces for frame bytes in and decoded measurements out.
interface hdec_req_if;
   logic                           valid;
   logic                           ready;
   logic [hdec_pkg::BYTE_W-1:0]    rx_byte;
   logic                           frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hdec_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  status;
   logic [hdec_pkg::WORD_W-1:0]           raw_temperature;
   logic [hdec_pkg::WORD_W-1:0]           raw_humidity;
   logic signed [hdec_pkg::TEMP_CENTI_W-1:0] temp_centi;
   logic [hdec_pkg::HUMID_CENTI_W-1:0]    humid_centi;

   modport source (output valid, output status, output raw_temperature, output raw_humidity,
                   output temp_centi, output humid_centi, input ready);
   modport sink   (input valid, input status, input raw_temperature, input raw_humidity,
                   input temp_centi, input humid_centi, output ready);
endinterface

>>> rtl/core/hdec_front.sv
// Front end: byte position tracking, CRC-8 checking and word assembly.
module hdec_front (
   input  logic                     clock,
   input  logic                     reset,
   hdec_req_if.sink                 req,
   input  logic                     queue_ready,
   output hdec_pkg::queue_port_type push
);

   typedef enum logic [2:0] {
      POS_TEMP_HI,
      POS_TEMP_LO,
      POS_TEMP_CRC,
      POS_HUMID_HI,
      POS_HUMID_LO,
      POS_HUMID_CRC
   } pos_type;

   pos_type                        pos_ff, pos_in, pos_eff;
   logic [hdec_pkg::BYTE_W-1:0]    crc_ff, crc_in, crc_eff;
   logic                           fail_ff, fail_in, fail_eff;
   logic [hdec_pkg::WORD_W-1:0]    temp_ff, temp_in;
   logic [hdec_pkg::WORD_W-1:0]    humid_ff, humid_in;
   logic                           accept;
   logic                           last_byte;

   assign req.ready = queue_ready;
   assign accept    = req.valid & req.ready;

   // A start mark restarts the frame before this byte is placed
   assign pos_eff  = req.frame_start ? POS_TEMP_HI : pos_ff;
   assign crc_eff  = req.frame_start ? hdec_pkg::CRC_INIT : crc_ff;
   assign fail_eff = req.frame_start ? 1'b0 : fail_ff;

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      fail_in   = fail_ff;
      temp_in   = temp_ff;
      humid_in  = humid_ff;
      last_byte = 1'b0;
      if (accept) begin
         case (pos_eff)
            POS_TEMP_HI: begin
               crc_in  = hdec_pkg::crc8_update(hdec_pkg::CRC_INIT, req.rx_byte);
               fail_in = 1'b0;
               temp_in = {req.rx_byte, temp_ff[7:0]};
               pos_in  = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
               crc_in  = hdec_pkg::crc8_update(crc_eff, req.rx_byte);
               fail_in = fail_eff;
               temp_in = {temp_ff[15:8], req.rx_byte};
               pos_in  = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
               fail_in = fail_eff | (crc_eff != req.rx_byte);
               crc_in  = hdec_pkg::CRC_INIT;
               pos_in  = POS_HUMID_HI;
            end
            POS_HUMID_HI: begin
               crc_in   = hdec_pkg::crc8_update(hdec_pkg::CRC_INIT, req.rx_byte);
               fail_in  = fail_eff;
               humid_in = {req.rx_byte, humid_ff[7:0]};
               pos_in   = POS_HUMID_LO;
            end
            POS_HUMID_LO: begin
               crc_in   = hdec_pkg::crc8_update(crc_eff, req.rx_byte);
               fail_in  = fail_eff;
               humid_in = {humid_ff[15:8], req.rx_byte};
               pos_in   = POS_HUMID_CRC;
            end
            default: begin
               last_byte = 1'b1;
               crc_in    = hdec_pkg::CRC_INIT;
               fail_in   = 1'b0;
               pos_in    = POS_TEMP_HI;
            end
         endcase
      end
   end

   assign push.valid                 = last_byte;
   assign push.frame.status          = fail_eff | (crc_eff != req.rx_byte);
   assign push.frame.raw_temperature = temp_ff;
   assign push.frame.raw_humidity    = humid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_TEMP_HI;
         crc_ff   <= hdec_pkg::CRC_INIT;
         fail_ff  <= 1'b0;
         temp_ff  <= '0;
         humid_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         fail_ff  <= fail_in;
         temp_ff  <= temp_in;
         humid_ff <= humid_in;
      end
   end

`ifndef SYNTHESIS
   a_restart_after_frame: assert property (@(posedge clock) disable iff (reset)
      push.valid |=> (pos_ff == POS_TEMP_HI) && (crc_ff == hdec_pkg::CRC_INIT) && !fail_ff)
      else $error("frame state not restarted after last byte");
`endif

endmodule

>>> rtl/core/hdec_queue.sv
// Short frame queue between the checking front end and the conversion back end.
module hdec_queue #(
   parameter int Depth = hdec_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hdec_pkg::queue_port_type push,
   output logic                     push_ready,
   output hdec_pkg::queue_port_type head,
   input  logic                     pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   hdec_pkg::frame_type  entries [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign do_push    = push.valid & push_ready;
   assign do_pop     = pop & head.valid;

   assign head.valid = (count_ff != '0);
   assign head.frame = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready)
      else $error("frame pushed into full queue");
`endif

endmodule

>>> rtl/core/hdec_back.sv
// Back end: scale raw words to hundredths and hold the result until taken.
module hdec_back (
   input  logic                     clock,
   input  logic                     reset,
   input  hdec_pkg::queue_port_type head,
   output logic                     pop,
   hdec_rsp_if.source               rsp
);

   // floor(n / 65535) for n below 2**31: n >> 16 is short by at most one
   function automatic logic [hdec_pkg::WORD_W-1:0] div_full_scale(
         input logic [hdec_pkg::PROD_W-1:0] n);
      logic [hdec_pkg::PROD_W-17:0] q0;
      logic [16:0]                  r0;
      logic [hdec_pkg::WORD_W-1:0]  q;
      q0 = n[hdec_pkg::PROD_W-1:16];
      r0 = {1'b0, n[15:0]} + 17'(q0);
      q  = 16'(q0);
      if (r0 >= {1'b0, hdec_pkg::FULL_SCALE}) begin
         q = q + 1'b1;
      end
      return q;
   endfunction

   logic                           s1_valid_ff;
   hdec_pkg::frame_type            s1_frame_ff;
   logic [hdec_pkg::PROD_W-1:0]    s1_tprod_ff, s1_tprod_in;
   logic [hdec_pkg::PROD_W-1:0]    s1_hprod_ff, s1_hprod_in;

   logic                           out_valid_ff;
   hdec_pkg::frame_type            out_frame_ff;
   logic signed [hdec_pkg::TEMP_CENTI_W-1:0] out_temp_ff, out_temp_in;
   logic [hdec_pkg::HUMID_CENTI_W-1:0]       out_humid_ff, out_humid_in;

   logic                           out_free;
   logic                           s1_free;
   logic [hdec_pkg::WORD_W-1:0]    t_quot, h_quot, t_shift;

   assign out_free = !out_valid_ff || rsp.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head.valid && s1_free;

   assign s1_tprod_in = hdec_pkg::PROD_W'(head.frame.raw_temperature)
                        * hdec_pkg::PROD_W'(hdec_pkg::TEMP_SCALE);
   assign s1_hprod_in = hdec_pkg::PROD_W'(head.frame.raw_humidity)
                        * hdec_pkg::PROD_W'(hdec_pkg::HUMID_SCALE);

   assign t_quot       = div_full_scale(s1_tprod_ff);
   assign h_quot       = div_full_scale(s1_hprod_ff);
   assign t_shift      = t_quot - hdec_pkg::TEMP_OFFSET;
   assign out_temp_in  = t_shift[hdec_pkg::TEMP_CENTI_W-1:0];
   assign out_humid_in = h_quot[hdec_pkg::HUMID_CENTI_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= head.valid;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload advances with its stage; no reset needed
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_frame_ff <= head.frame;
         s1_tprod_ff <= s1_tprod_in;
         s1_hprod_ff <= s1_hprod_in;
      end
      if (out_free && s1_valid_ff) begin
         out_frame_ff <= s1_frame_ff;
         out_temp_ff  <= out_temp_in;
         out_humid_ff <= out_humid_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.status          = out_frame_ff.status;
   assign rsp.raw_temperature = out_frame_ff.raw_temperature;
   assign rsp.raw_humidity    = out_frame_ff.raw_humidity;
   assign rsp.temp_centi      = out_temp_ff;
   assign rsp.humid_centi     = out_humid_ff;

`ifndef SYNTHESIS
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_temp_ff >= -15'sd4500) && (out_temp_ff <= 15'sd13000))
      else $error("temperature out of range");
   a_humid_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_humid_ff <= 14'd10000))
      else $error("humidity out of range");
`endif

endmodule

>>> rtl/core/humidity_temp_frame_decoder_unit.sv
// Sensor frame decoder: one frame byte per cycle in, one converted measurement per frame out.
// Throughput: one byte accepted every cycle; ready drops only when the frame queue is full.
// Path: after the sixth byte is accepted, a frame goes through the queue write, the multiply
//   stage and the divide-and-offset into the output register; a busy output can hold it back.
// Reset: clears byte position, CRC, failure flag, queue pointers and stage valids at once.
module humidity_temp_frame_decoder_unit #(
   parameter int QueueDepth = hdec_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   hdec_req_if.sink    req_chan,
   hdec_rsp_if.source  rsp_chan
);

   hdec_pkg::queue_port_type push;
   hdec_pkg::queue_port_type head;
   logic                     queue_ready;
   logic                     pop;

   hdec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .queue_ready (queue_ready),
      .push        (push)
   );

   hdec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (queue_ready),
      .head       (head),
      .pop        (pop)
   );

   hdec_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
